// ===== rtl/rra_pkg.sv =====
// shared types, constants and control interfaces of the round-robin block allocator
package rra_pkg;

    localparam int ID_W            = 20;
    localparam int WANT_W          = 5;
    localparam int BLOCK_W         = 6;
    localparam int POOL_W          = 2;
    localparam int MAX_GRANTS      = 16;
    localparam int DEF_MAX_REQUESTS    = 16;
    localparam int DEF_BLOCKS_PER_ZONE = 16;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } rra_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // store the accepted request
        logic start;       // slot closed, reset allocation counters
        logic step;        // evaluate the entry at the walk index
        logic flush_emit;  // send the held grant as the final one
        logic finish;      // empty the store, back to loading
    } rra_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic entry_short;  // current entry still wants a block this pass
        logic held_valid;   // a grant waits for its successor
        logic out_free;     // output register can take a transfer
        logic alloc_end;    // this step ends allocation
    } rra_status_t;

endpackage

// ===== rtl/round_robin_rb_allocator.sv =====
// top level of the round-robin resource block allocator
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_valid/cfg_ready   cfg_pool_select
//  request   in         s_valid/s_ready       s_vehicle_id, s_wanted_blocks, s_slot_end
//  grant     out        m_valid/m_ready       m_granted_vehicle, m_block_number, m_final_grant
//
// requests are stored one per cycle; the one marked slot end starts allocation
// allocation visits one store entry at a time, reading it (registered) then evaluating it,
// and runs at most one pass per granted block plus one, over all stored entries
// a held grant goes out only when the next one is found or allocation ends,
// so output stalls hold the walk; no request is taken until the slot is done
// synchronous active-low reset empties the store and sets pool_select to zero
module round_robin_rb_allocator #(
    parameter int MAX_REQUESTS    = rra_pkg::DEF_MAX_REQUESTS,
    parameter int BLOCKS_PER_ZONE = rra_pkg::DEF_BLOCKS_PER_ZONE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rra_pkg::POOL_W-1:0]  cfg_pool_select,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rra_pkg::ID_W-1:0]    s_vehicle_id,
    input  logic [rra_pkg::WANT_W-1:0]  s_wanted_blocks,
    input  logic                        s_slot_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rra_pkg::ID_W-1:0]    m_granted_vehicle,
    output logic [rra_pkg::BLOCK_W-1:0] m_block_number,
    output logic                        m_final_grant
);
    import rra_pkg::*;

    rra_cmd_t    cmd;
    rra_status_t status;

    assign cfg_ready = 1'b1;

    rra_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_slot_end (s_slot_end),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rra_datapath #(
        .MAX_REQUESTS    (MAX_REQUESTS),
        .BLOCKS_PER_ZONE (BLOCKS_PER_ZONE)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_pool_select   (cfg_pool_select),
        .s_vehicle_id      (s_vehicle_id),
        .s_wanted_blocks   (s_wanted_blocks),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_vehicle (m_granted_vehicle),
        .m_block_number    (m_block_number),
        .m_final_grant     (m_final_grant),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

// ===== rtl/rra_ctrl.sv =====
// controller state machine: loading, walking the store, final flush
module rra_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_slot_end,
    output logic                 s_ready,
    input  rra_pkg::rra_status_t status,
    output rra_pkg::rra_cmd_t    cmd
);
    import rra_pkg::*;

    rra_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_slot_end) begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // a grant only stalls when the held one cannot leave
                if (!status.entry_short || !status.held_valid || status.out_free) begin
                    cmd.step   = 1'b1;
                    state_next = status.alloc_end ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (!status.held_valid) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end else if (status.out_free) begin
                    cmd.flush_emit = 1'b1;
                    cmd.finish     = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/rra_datapath.sv =====
// request store, pass and block counters, held grant and output register
module rra_datapath #(
    parameter int MAX_REQUESTS    = rra_pkg::DEF_MAX_REQUESTS,
    parameter int BLOCKS_PER_ZONE = rra_pkg::DEF_BLOCKS_PER_ZONE
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [rra_pkg::POOL_W-1:0]  cfg_pool_select,
    input  logic [rra_pkg::ID_W-1:0]    s_vehicle_id,
    input  logic [rra_pkg::WANT_W-1:0]  s_wanted_blocks,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rra_pkg::ID_W-1:0]    m_granted_vehicle,
    output logic [rra_pkg::BLOCK_W-1:0] m_block_number,
    output logic                        m_final_grant,
    input  rra_pkg::rra_cmd_t           cmd,
    output rra_pkg::rra_status_t        status
);
    import rra_pkg::*;

    localparam int LIMIT  = (BLOCKS_PER_ZONE < MAX_GRANTS) ? BLOCKS_PER_ZONE : MAX_GRANTS;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int NB_W   = $clog2(LIMIT + 1);
    localparam int BASE_W = $clog2(4 * BLOCKS_PER_ZONE) + 1;
    localparam int SUM_W  = (BASE_W > BLOCK_W) ? BASE_W : BLOCK_W;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [WANT_W-1:0] want;
    } rra_entry_t;

    rra_entry_t store_mem [MAX_REQUESTS];
    rra_entry_t rd_reg;

    logic [POOL_W-1:0]  pool_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WANT_W-1:0]  pass_reg;
    logic [NB_W-1:0]    nb_reg;
    logic               progress_reg;
    logic               held_valid_reg;
    logic [ID_W-1:0]    held_id_reg;
    logic [BLOCK_W-1:0] held_block_reg;
    logic               m_valid_reg;
    logic [ID_W-1:0]    m_id_reg;
    logic [BLOCK_W-1:0] m_block_reg;
    logic               m_final_reg;

    logic               entry_short;
    logic               last_entry;
    logic               pool_done;
    logic               alloc_end;
    logic               out_free;
    logic               push;
    logic [SUM_W-1:0]   block_sum;

    always_ff @(posedge aclk) begin
        if (cmd.load && (count_reg < CNT_W'(MAX_REQUESTS))) begin
            store_mem[count_reg[IDX_W-1:0]] <= '{id: s_vehicle_id, want: s_wanted_blocks};
        end
        rd_reg <= store_mem[idx_reg];
    end

    // a request still short in this pass got a block in every earlier pass
    assign entry_short = rd_reg.want > pass_reg;
    assign last_entry  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign pool_done   = entry_short && ((nb_reg + NB_W'(1)) == NB_W'(LIMIT));
    assign alloc_end   = pool_done || (last_entry && !(progress_reg || entry_short));
    assign out_free    = !m_valid_reg || m_ready;
    assign push        = (cmd.step && entry_short && held_valid_reg) || cmd.flush_emit;
    assign block_sum   = SUM_W'(pool_reg) * SUM_W'(BLOCKS_PER_ZONE) + SUM_W'(nb_reg);

    assign status.entry_short = entry_short;
    assign status.held_valid  = held_valid_reg;
    assign status.out_free    = out_free;
    assign status.alloc_end   = alloc_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pass_reg       <= '0;
            nb_reg         <= '0;
            progress_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pool_reg <= cfg_pool_select;
            end
            if (cmd.load && (count_reg < CNT_W'(MAX_REQUESTS))) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.start) begin
                idx_reg        <= '0;
                pass_reg       <= '0;
                nb_reg         <= '0;
                progress_reg   <= 1'b0;
                held_valid_reg <= 1'b0;
            end
            if (cmd.step) begin
                if (entry_short) begin
                    held_valid_reg <= 1'b1;
                    nb_reg         <= nb_reg + NB_W'(1);
                end
                if (last_entry) begin
                    // wrap for the next pass
                    idx_reg      <= '0;
                    pass_reg     <= pass_reg + WANT_W'(1);
                    progress_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (entry_short) begin
                        progress_reg <= 1'b1;
                    end
                end
            end
            if (cmd.finish) begin
                count_reg      <= '0;
                held_valid_reg <= 1'b0;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && entry_short) begin
            held_id_reg    <= rd_reg.id;
            held_block_reg <= block_sum[BLOCK_W-1:0];
        end
        if (push) begin
            m_id_reg    <= held_id_reg;
            m_block_reg <= held_block_reg;
            m_final_reg <= cmd.flush_emit;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_vehicle = m_id_reg;
    assign m_block_number    = m_block_reg;
    assign m_final_grant     = m_final_reg;

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("grant pushed into a full output register");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && entry_short |-> nb_reg < NB_W'(LIMIT))
        else $error("grant beyond the pool");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (count_reg == '0) && !held_valid_reg)
        else $error("store not emptied after the slot");

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for round_robin_rb_allocator: directed table then random slots
`timescale 1ns / 1ps

module testbench;
    import rra_pkg::*;

    localparam int MAX_REQ       = DEF_MAX_REQUESTS;
    localparam int ZONE_BLOCKS   = DEF_BLOCKS_PER_ZONE;
    localparam int GRANT_CAP     = (ZONE_BLOCKS < MAX_GRANTS) ? ZONE_BLOCKS : MAX_GRANTS;
    localparam int SETTLE_CYCLES = 600;
    localparam int STUCK_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 305;

    typedef struct packed {
        logic [ID_W-1:0]    vehicle;
        logic [BLOCK_W-1:0] block;
        logic               last;
    } grant_t;

    // one directed row; rep sends ids id, id+1, ... with slot_end only on the final copy
    typedef struct packed {
        logic [POOL_W-1:0]  pool;
        logic [ID_W-1:0]    id;
        logic [WANT_W-1:0]  want;
        logic               last;
        logic [4:0]         rep;
        logic               typed;
        logic               n_typed;
        logic [BLOCK_W-1:0] t_block;
    } dir_row_t;

    localparam int N_DIRECTED = 10;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{2'd0, 20'd0,      5'd1,  1'b1, 5'd1,  1'b1, 1'b1, 6'd0},
        // zero wanted alone: empty slot
        '{2'd0, 20'd999999, 5'd0,  1'b1, 5'd1,  1'b1, 1'b0, 6'd0},
        '{2'd0, 20'hFFFFF,  5'd31, 1'b1, 5'd1,  1'b0, 1'b0, 6'd0},
        '{2'd0, 20'd10,     5'd2,  1'b0, 5'd1,  1'b0, 1'b0, 6'd0},
        '{2'd0, 20'd11,     5'd5,  1'b0, 5'd1,  1'b0, 1'b0, 6'd0},
        '{2'd0, 20'd10,     5'd1,  1'b1, 5'd1,  1'b0, 1'b0, 6'd0},
        // fill the store, then a dropped request that still closes the slot
        '{2'd0, 20'd100,    5'd1,  1'b0, 5'd16, 1'b0, 1'b0, 6'd0},
        '{2'd0, 20'd200,    5'd3,  1'b1, 5'd1,  1'b0, 1'b0, 6'd0},
        '{2'd3, 20'd7,      5'd1,  1'b1, 5'd1,  1'b1, 1'b1, 6'd48},
        '{2'd2, 20'd8,      5'd1,  1'b1, 5'd1,  1'b1, 1'b1, 6'd32}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [POOL_W-1:0]  cfg_pool_select = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ID_W-1:0]    s_vehicle_id = '0;
    logic [WANT_W-1:0]  s_wanted_blocks = '0;
    logic               s_slot_end = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ID_W-1:0]    m_granted_vehicle;
    logic [BLOCK_W-1:0] m_block_number;
    logic               m_final_grant;

    // predictor state
    logic [ID_W-1:0]    slot_ids [MAX_REQ];
    logic [WANT_W-1:0]  slot_wants [MAX_REQ];
    int                 slot_fill = 0;
    logic [POOL_W-1:0]  zone_pool = '0;
    grant_t             fresh_grants [$];
    grant_t             grants_due [$];

    int errors = 0;
    int requests_sent = 0;
    int slots_closed = 0;
    int grants_seen = 0;
    int pool_writes = 0;
    int burst_left = 0;
    int stuck_cycles = 0;
    int rx_cycle = 0;

    round_robin_rb_allocator #(
        .MAX_REQUESTS    (MAX_REQ),
        .BLOCKS_PER_ZONE (ZONE_BLOCKS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_pool_select   (cfg_pool_select),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_vehicle_id      (s_vehicle_id),
        .s_wanted_blocks   (s_wanted_blocks),
        .s_slot_end        (s_slot_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_vehicle (m_granted_vehicle),
        .m_block_number    (m_block_number),
        .m_final_grant     (m_final_grant)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void append_fresh(input grant_t g);
        fresh_grants = {fresh_grants, g};
    endfunction

    function automatic void append_due(input grant_t g);
        grants_due = {grants_due, g};
    endfunction

    // hand out the pool in passes, one block per short request per pass
    function automatic void close_slot();
        int unsigned given [MAX_REQ];
        int unsigned used;
        bit          granted_any;
        grant_t      g;
        used = 0;
        granted_any = 1'b1;
        foreach (given[i]) given[i] = 0;
        while (granted_any && used < GRANT_CAP) begin
            granted_any = 1'b0;
            for (int i = 0; i < slot_fill; i++) begin
                if (used >= GRANT_CAP) break;
                if (given[i] < slot_wants[i]) begin
                    g.vehicle = slot_ids[i];
                    g.block = BLOCK_W'(zone_pool * ZONE_BLOCKS + used);
                    g.last = 1'b0;
                    append_fresh(g);
                    given[i]++;
                    used++;
                    granted_any = 1'b1;
                end
            end
        end
        if (fresh_grants.size() > 0) begin
            fresh_grants[fresh_grants.size() - 1].last = 1'b1;
        end
        slot_fill = 0;
    endfunction

    function automatic void take_request(input logic [ID_W-1:0] id,
                                         input logic [WANT_W-1:0] want, input logic last);
        fresh_grants.delete();
        if (slot_fill < MAX_REQ) begin
            slot_ids[slot_fill] = id;
            slot_wants[slot_fill] = want;
            slot_fill++;
        end
        if (last) begin
            slots_closed++;
            close_slot();
        end
    endfunction

    function automatic void queue_fresh();
        foreach (fresh_grants[j]) append_due(fresh_grants[j]);
    endfunction

    task automatic send_request(input logic [ID_W-1:0] id, input logic [WANT_W-1:0] want,
                                input logic last);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid = 1'b1;
        s_vehicle_id = id;
        s_wanted_blocks = want;
        s_slot_end = last;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        take_request(id, want, last);
    endtask

    // only called with the store empty; waits out the last slot before the transfer
    task automatic write_pool(input logic [POOL_W-1:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        while (grants_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_pool_select = value;
        do @(posedge aclk); while (!cfg_ready);
        zone_pool = value;
        pool_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // receiver: steps through four ready modes in turn, from always ready to heavy stalls
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ((rx_cycle % 7) < 3);
            default: m_ready <= $urandom_range(0, 1);
        endcase
    end

    function automatic void check_field(input string name, input int unsigned want_val,
                                        input int unsigned got_val);
        if (want_val != got_val) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_val,
                     got_val);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            grants_seen++;
            if (grants_due.size() == 0) begin
                errors++;
                $display("%0t: grant with none expected: vehicle %0d block %0d final %0b",
                         $time, m_granted_vehicle, m_block_number, m_final_grant);
            end else begin
                grant_t g;
                g = grants_due.pop_front();
                check_field("granted_vehicle", g.vehicle, m_granted_vehicle);
                check_field("block_number", g.block, m_block_number);
                check_field("final_grant", g.last, m_final_grant);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d grants outstanding", $time,
                     STUCK_LIMIT, grants_due.size());
            $display("round_robin_rb_allocator test failed");
            $finish;
        end
    end

    initial begin
        dir_row_t          row;
        int                random_sent;
        int                slot_size;
        int                pick;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   prev_id;
        logic [WANT_W-1:0] want;
        bit                first_slot;

        random_sent = 0;
        prev_id = '0;
        first_slot = 1'b1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DIRECTED[r]) begin
            row = DIRECTED[r];
            if (row.pool != zone_pool) write_pool(row.pool);
            for (int k = 0; k < row.rep; k++) begin
                send_request(row.id + ID_W'(k), row.want, row.last && (k == row.rep - 1));
                if (row.typed) begin
                    fresh_grants.delete();
                    if (row.n_typed) append_due('{row.id, row.t_block, 1'b1});
                end else begin
                    queue_fresh();
                end
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            if (first_slot || $urandom_range(0, 5) == 0) begin
                write_pool(first_slot ? POOL_W'(0) : POOL_W'($urandom_range(0, 3)));
                first_slot = 1'b0;
            end
            // now and then fill or overfill the store so any extra requests get dropped
            slot_size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20)
                                                   : $urandom_range(1, 6);
            for (int k = 0; k < slot_size; k++) begin
                id = ($urandom_range(0, 4) == 0) ? prev_id : ID_W'($urandom_range(0, 20'hFFFFF));
                pick = $urandom_range(0, 7);
                if (pick == 0) want = '0;
                else if (pick == 1) want = WANT_W'($urandom_range(17, 31));
                else want = WANT_W'($urandom_range(1, 6));
                send_request(id, want, k == slot_size - 1);
                queue_fresh();
                prev_id = id;
                random_sent++;
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (grants_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests over %0d slots, %0d grants checked, %0d pool writes",
                 requests_sent, slots_closed, grants_seen, pool_writes);
        if (errors == 0) begin
            $display("round_robin_rb_allocator test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("round_robin_rb_allocator test failed");
        end
        $finish;
    end

endmodule
